>>> design/lga_pkg.sv
// Package for the aging life grid step block: grid geometry, request codes,
// register indexes and colour helper. No dependencies.
`default_nettype none
package lga_pkg;
  localparam int unsigned GridCols = 64;
  localparam int unsigned GridRows = 64;
  localparam int unsigned ColW = $clog2(GridCols);
  localparam int unsigned RowW = $clog2(GridRows);
  localparam int unsigned Cells = GridCols * GridRows;
  localparam int unsigned AddrW = $clog2(Cells);
  localparam int unsigned CntW = 13;
  localparam int unsigned WideW = AddrW + 1;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_GEN   = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    CFG_LEVEL_ONE   = 3'd0,
    CFG_LEVEL_TWO   = 3'd1,
    CFG_LEVEL_THREE = 3'd2,
    CFG_MIN_CHANGES = 3'd3,
    CFG_MIN_LIVE    = 3'd4
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic rgb_t colour_of(logic [7:0] a, logic [7:0] l1, logic [7:0] l2,
                                     logic [7:0] l3);
    rgb_t c;
    logic [7:0] d;
    if (a == 8'd0) begin
      c = '{8'd10, 8'd20, 8'd0};
    end else if (a >= l2) begin
      d = l3 - a;
      c = '{8'd255, 8'((d << 3) + (d << 1)), 8'd0};
    end else if (a >= l1) begin
      d = a - l1;
      c = '{8'd0, 8'((d << 3) + (d << 1)), 8'd255};
    end else begin
      c = '{8'd50, 8'd255, 8'd0};
    end
    return c;
  endfunction
endpackage
`default_nettype wire

>>> design/life_grid_aging_step.sv
// Top level of the aging life grid step block (B3/S23 on a torus).
// Depends on lga_pkg.
`default_nettype none
// Command interface: an item is taken when start_i is high and busy_o low; the
// result shows for one cycle with done_o and cannot be held off. A write, a
// read (one memory read) or an unknown request holds busy_o high in a single
// state (ST_DONE or ST_READ) and raises done_o in the cycle after that. A
// generation copies the grid into a second memory, then visits every cell
// once: one read of the copy per neighbour, one a cycle, with the own age from
// the main store and the result and the write back in the last phase. The scan
// pace is set by the single read port of the shadow memory. The cell store is
// cleared after reset in one pass over every cell, during which busy_o is
// high; configuration is taken at all times.
module life_grid_aging_step (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  output logic                 busy_o,
  input  wire  [1:0]           req_type_i,
  input  wire  [5:0]           col_i,
  input  wire  [5:0]           row_i,
  input  wire  [7:0]           age_in_i,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [2:0]           cfg_index_i,
  input  wire  [12:0]          cfg_data_i,
  output logic                 done_o,
  output logic [7:0]           age_out_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic [12:0]          live_before_o,
  output logic [12:0]          change_count_o,
  output logic                 refill_wanted_o
);
  import lga_pkg::*;

  // Memories: main store and shadow copy used for neighbour reads.
  logic [7:0] mem_a [Cells];
  logic [7:0] mem_b [Cells];

  state_e state_q, state_d;
  logic [7:0] lvl1_q, lvl2_q, lvl3_q;
  logic [12:0] minch_q, minlv_q;
  logic clr_q;
  logic [AddrW:0] clr_cnt_q;
  logic [AddrW:0] idx_q, idx_d;        // cell index in copy/scan
  logic [3:0] ph_q, ph_d;              // neighbour phase 0..9
  logic [3:0] nb_q, nb_d;              // neighbour count
  logic [7:0] own_q, own_d;            // own age from main store
  logic [WideW-1:0] live_q, live_d, chg_q, chg_d;
  logic [AddrW-1:0] rd_addr;
  logic [7:0] a_rd_q, b_rd_q;
  logic [AddrW-1:0] cp_wr_q;
  logic cp_we_q;
  logic [AddrW-1:0] a_waddr;
  logic [7:0] a_wdata;
  logic a_we;
  logic [AddrW-1:0] cell_addr;
  logic [RowW-1:0] cur_row, nrow;
  logic [ColW-1:0] cur_col, ncol;
  logic [7:0] new_age;
  logic is_chg;
  logic in_grid;
  logic [1:0] req_q;
  logic accept;

  assign cfg_ready_o = 1'b1;
  assign busy_o = clr_q || (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign in_grid = ({2'b0, col_i} < 8'(GridCols)) && ({2'b0, row_i} < 8'(GridRows));
  assign cell_addr = idx_q[AddrW-1:0];
  assign cur_row = cell_addr[AddrW-1 -: RowW];
  assign cur_col = cell_addr[ColW-1:0];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl1_q <= 8'd10; lvl2_q <= 8'd27; lvl3_q <= 8'd51;
      minch_q <= 13'd50; minlv_q <= 13'd100;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LEVEL_ONE:   lvl1_q <= cfg_data_i[7:0];
        CFG_LEVEL_TWO:   lvl2_q <= cfg_data_i[7:0];
        CFG_LEVEL_THREE: lvl3_q <= cfg_data_i[7:0];
        CFG_MIN_CHANGES: minch_q <= cfg_data_i;
        CFG_MIN_LIVE:    minlv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clearing pass after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == (AddrW+1)'(Cells - 1)) clr_q <= 1'b0;
    end
  end

  // Neighbour address for the current phase; phase 8 reads the cell itself.
  always_comb begin
    nrow = cur_row;
    ncol = cur_col;
    case (ph_q)
      4'd0, 4'd1, 4'd2:
        nrow = (cur_row == '0) ? RowW'(GridRows - 1) : cur_row - 1'b1;
      4'd5, 4'd6, 4'd7:
        nrow = (cur_row == RowW'(GridRows - 1)) ? '0 : cur_row + 1'b1;
      default: nrow = cur_row;
    endcase
    case (ph_q)
      4'd0, 4'd3, 4'd5:
        ncol = (cur_col == '0) ? ColW'(GridCols - 1) : cur_col - 1'b1;
      4'd2, 4'd4, 4'd7:
        ncol = (cur_col == ColW'(GridCols - 1)) ? '0 : cur_col + 1'b1;
      default: ncol = cur_col;
    endcase
  end

  // Read address: the shadow copy always, the main store outside the scan.
  always_comb begin
    case (state_q)
      ST_COPY: rd_addr = cell_addr;
      ST_SCAN: rd_addr = {nrow, ncol};
      default: rd_addr = AddrW'({row_i[RowW-1:0], col_i[ColW-1:0]});
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_rd_q <= mem_a[(state_q == ST_SCAN) ? cell_addr : rd_addr];
    b_rd_q <= mem_b[rd_addr];
    if (a_we) mem_a[a_waddr] <= a_wdata;
    if (cp_we_q) mem_b[cp_wr_q] <= a_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_we_q <= 1'b0;
    end else begin
      cp_we_q <= (state_q == ST_COPY) && (idx_q < (AddrW+1)'(Cells));
    end
  end
  always_ff @(posedge clk_i) begin
    cp_wr_q <= cell_addr;
    if (accept) begin
      req_q <= req_type_i;
    end
  end

  // Rule evaluation on phase 9: count complete, own age read.
  always_comb begin
    new_age = own_q;
    is_chg = 1'b0;
    if (own_q == 8'd0) begin
      if (nb_q == 4'd3) begin new_age = 8'd1; is_chg = 1'b1; end
    end else if (nb_q == 4'd2 || nb_q == 4'd3) begin
      new_age = (own_q >= lvl3_q) ? 8'd0 : own_q + 8'd1;
    end else begin
      new_age = 8'd0; is_chg = 1'b1;
    end
  end

  always_comb begin
    a_we = 1'b0;
    a_waddr = cell_addr;
    a_wdata = new_age;
    if (clr_q) begin
      a_we = 1'b1; a_waddr = clr_cnt_q[AddrW-1:0]; a_wdata = '0;
    end else if (accept && req_type_i == REQ_WRITE && in_grid) begin
      a_we = 1'b1; a_waddr = rd_addr; a_wdata = age_in_i;
    end else if (state_q == ST_SCAN && ph_q == 4'd9) begin
      a_we = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) begin
        case (req_type_i)
          REQ_READ: state_d = ST_READ;
          REQ_GEN:  state_d = ST_COPY;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_READ: state_d = ST_IDLE;
      ST_COPY: if (idx_q == (AddrW+1)'(Cells)) state_d = ST_SCAN;
      ST_SCAN: if (ph_q == 4'd9 && idx_q == (AddrW+1)'(Cells - 1)) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath counters.
  always_comb begin
    idx_d = idx_q; ph_d = ph_q; nb_d = nb_q; own_d = own_q;
    live_d = live_q; chg_d = chg_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0; ph_d = '0; nb_d = '0; live_d = '0; chg_d = '0;
      end
      ST_COPY: begin
        if (idx_q == (AddrW+1)'(Cells)) idx_d = '0;
        else idx_d = idx_q + 1'b1;
      end
      ST_SCAN: begin
        // Phase p reads neighbour p; its data lands in phase p+1.
        if (ph_q >= 4'd1 && ph_q <= 4'd8) nb_d = nb_q + {3'b0, b_rd_q != 8'd0};
        if (ph_q == 4'd1) own_d = a_rd_q;
        if (ph_q == 4'd9) begin
          ph_d = '0; nb_d = '0;
          idx_d = idx_q + 1'b1;
          live_d = live_q + {{AddrW{1'b0}}, own_q != 8'd0};
          chg_d = chg_q + {{AddrW{1'b0}}, is_chg};
        end else begin
          ph_d = ph_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q <= '0; ph_q <= '0; nb_q <= '0;
      live_q <= '0; chg_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d; ph_q <= ph_d; nb_q <= nb_d;
      live_q <= live_d; chg_q <= chg_d;
    end
  end
  always_ff @(posedge clk_i) own_q <= own_d;

  // Result register; every field zero unless the request sets it.
  logic read_ok_q;
  rgb_t rgb;
  assign rgb = colour_of(a_rd_q, lvl1_q, lvl2_q, lvl3_q);
  always_ff @(posedge clk_i) if (accept) read_ok_q <= in_grid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
      age_out_o <= '0; red_o <= '0; green_o <= '0; blue_o <= '0;
      live_before_o <= '0; change_count_o <= '0; refill_wanted_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      age_out_o <= '0; red_o <= '0; green_o <= '0; blue_o <= '0;
      live_before_o <= '0; change_count_o <= '0; refill_wanted_o <= 1'b0;
      if (state_q == ST_READ) begin
        done_o <= 1'b1;
        if (read_ok_q) begin
          age_out_o <= a_rd_q;
          red_o <= rgb.red; green_o <= rgb.green; blue_o <= rgb.blue;
        end
      end else if (state_q == ST_DONE) begin
        done_o <= 1'b1;
        if (req_q == REQ_GEN) begin
          live_before_o <= (live_q > WideW'(8191)) ? 13'd8191 : 13'(live_q);
          change_count_o <= (chg_q > WideW'(8191)) ? 13'd8191 : 13'(chg_q);
          refill_wanted_o <= (chg_q < WideW'(minch_q)) || (live_q < WideW'(minlv_q));
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> design/lga_checker.sv
// Port-level checker for life_grid_aging_step, bound to the top level.
// Depends on lga_pkg.
`default_nettype none
module lga_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        start_i,
  input wire        busy_o,
  input wire        done_o,
  input wire [7:0]  red_o,
  input wire [7:0]  age_out_o,
  input wire [12:0] live_before_o,
  input wire        refill_wanted_o
);
  import lga_pkg::*;

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held two cycles");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(done_o) && $past(busy_o) |-> !busy_o) else $error("busy after result");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (age_out_o == 8'd0 && red_o == 8'd0 && live_before_o == 13'd0
                 && !refill_wanted_o)) else $error("result lines not zero");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o) else $error("accept lost");
endmodule

bind life_grid_aging_step lga_checker u_lga_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .done_o(done_o), .red_o(red_o), .age_out_o(age_out_o),
  .live_before_o(live_before_o), .refill_wanted_o(refill_wanted_o)
);
`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for life_grid_aging_step: directed and random requests
// predicted against a software copy of the aging grid. Depends on lga_pkg.
`timescale 1ns / 1ps

import lga_pkg::*;

typedef struct packed {
  logic [7:0]  age;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [12:0] live;
  logic [12:0] changes;
  logic        refill;
} grid_result_t;

// Shadow grid, register copy and the queue of results still owed by the block.
class grid_scoreboard;
  logic [7:0]   ages [Cells];
  logic [7:0]   lvl_one, lvl_two, lvl_three;
  logic [12:0]  min_chg, min_live;
  grid_result_t owed [$];
  int           mismatches, strays, checked, gens;

  function new();
    foreach (ages[i]) ages[i] = 8'd0;
    lvl_one = 8'd10; lvl_two = 8'd27; lvl_three = 8'd51;
    min_chg = 13'd50; min_live = 13'd100;
    mismatches = 0; strays = 0; checked = 0; gens = 0;
  endfunction

  function void set_reg(cfg_e idx, logic [12:0] val);
    case (idx)
      CFG_LEVEL_ONE:   lvl_one = val[7:0];
      CFG_LEVEL_TWO:   lvl_two = val[7:0];
      CFG_LEVEL_THREE: lvl_three = val[7:0];
      CFG_MIN_CHANGES: min_chg = val;
      CFG_MIN_LIVE:    min_live = val;
      default: ;
    endcase
  endfunction

  function int pending();
    return owed.size();
  endfunction

  // Advance the shadow grid one B3/S23 generation on the torus.
  function void step_grid(output int live, output int changes);
    logic [3:0] nbr [Cells];
    int ru, rd, cl, cr, n;
    live = 0;
    changes = 0;
    for (int r = 0; r < GridRows; r++) begin
      ru = (r + GridRows - 1) % GridRows;
      rd = (r + 1) % GridRows;
      for (int c = 0; c < GridCols; c++) begin
        cl = (c + GridCols - 1) % GridCols;
        cr = (c + 1) % GridCols;
        n = (ages[ru*GridCols+cl] != 0) + (ages[ru*GridCols+c] != 0)
          + (ages[ru*GridCols+cr] != 0) + (ages[r*GridCols+cl] != 0)
          + (ages[r*GridCols+cr] != 0) + (ages[rd*GridCols+cl] != 0)
          + (ages[rd*GridCols+c] != 0) + (ages[rd*GridCols+cr] != 0);
        nbr[r*GridCols+c] = 4'(n);
        if (ages[r*GridCols+c] != 0) live++;
      end
    end
    for (int i = 0; i < Cells; i++) begin
      if (nbr[i] == 3 && ages[i] == 0) begin
        ages[i] = 8'd1;
        changes++;
      end else if (nbr[i] == 2 || nbr[i] == 3) begin
        // old-age death is not a rule change
        if (ages[i] != 0) ages[i] = (ages[i] >= lvl_three) ? 8'd0 : ages[i] + 8'd1;
      end else if (ages[i] != 0) begin
        ages[i] = 8'd0;
        changes++;
      end
    end
  endfunction

  function void note_request(req_e req, logic [5:0] col, logic [5:0] row, logic [7:0] age);
    grid_result_t res;
    int a, live, changes;
    res = '0;
    case (req)
      REQ_WRITE: ages[row*GridCols+col] = age;
      REQ_READ: begin
        a = ages[row*GridCols+col];
        res.age = 8'(a);
        if (a == 0) begin
          res.red = 8'd10; res.green = 8'd20; res.blue = 8'd0;
        end else if (a >= lvl_two) begin
          res.red = 8'd255; res.green = 8'((int'(lvl_three) - a) * 10); res.blue = 8'd0;
        end else if (a >= lvl_one) begin
          res.red = 8'd0; res.green = 8'((a - int'(lvl_one)) * 10); res.blue = 8'd255;
        end else begin
          res.red = 8'd50; res.green = 8'd255; res.blue = 8'd0;
        end
      end
      REQ_GEN: begin
        step_grid(live, changes);
        gens++;
        res.live = 13'(live);
        res.changes = 13'(changes);
        res.refill = (changes < min_chg) || (live < min_live);
      end
      default: ;
    endcase
    owed.push_back(res);
  endfunction

  function void check_result(grid_result_t got);
    grid_result_t want;
    if (owed.size() == 0) begin
      strays++;
      if (strays + mismatches <= 10) $display("tb: result with nothing owed: %p", got);
      return;
    end
    want = owed.pop_front();
    checked++;
    if (got !== want) begin
      mismatches++;
      if (mismatches + strays <= 10)
        $display("tb: mismatch #%0d\n  want %p\n  got  %p", mismatches, want, got);
    end
  endfunction
endclass

module tb;
  logic        clk_i, rst_ni, start_i, cfg_valid_i;
  logic [1:0]  req_type_i;
  logic [5:0]  col_i, row_i;
  logic [7:0]  age_in_i;
  logic [2:0]  cfg_index_i;
  logic [12:0] cfg_data_i;
  logic        busy_o, cfg_ready_o, done_o, refill_wanted_o;
  logic [7:0]  age_out_o, red_o, green_o, blue_o;
  logic [12:0] live_before_o, change_count_o;

  grid_scoreboard sb = new();
  int burst_left = 0;
  int ox, oy;

  life_grid_aging_step uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Results cannot be held off: take every strobed beat.
  always @(posedge clk_i) begin
    if (done_o)
      sb.check_result('{age_out_o, red_o, green_o, blue_o, live_before_o,
                        change_count_o, refill_wanted_o});
  end

  // Present one request and hold it until the block takes the beat. Start
  // stays high into the next request while a burst lasts; between bursts,
  // drop it for a random gap, though now and then it stays high.
  task automatic issue(req_e req, int col, int row, int age);
    int gap;
    start_i    <= 1'b1;
    req_type_i <= req;
    col_i      <= 6'(col);
    row_i      <= 6'(row);
    age_in_i   <= 8'(age);
    do @(posedge clk_i); while (busy_o);
    sb.note_request(req, 6'(col), 6'(row), 8'(age));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Let the block drain, then hold start low for a short settle.
  task automatic drain();
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Write all five registers back to back; the block must be idle.
  task automatic program_regs(int l1, int l2, int l3, int mc, int ml);
    int vals [5];
    vals = '{l1, l2, l3, mc, ml};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i  <= 13'(vals[i]);
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(cfg_e'(i), 13'(vals[i]));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic: writes, mostly clustered in a small window so patterns
  // live and die, reads over the window and the whole grid, a few
  // generations and some unknown requests as noise.
  task automatic random_phase(int count);
    int pick, gens_here;
    gens_here = 0;
    ox = $urandom_range(0, 63);
    oy = $urandom_range(0, 63);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 4) == 0)
          issue(REQ_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom_range(0, 255));
        else
          issue(REQ_WRITE, (ox + $urandom_range(0, 5)) % 64, (oy + $urandom_range(0, 5)) % 64,
                ($urandom_range(0, 2) == 0) ? 0 :
                ($urandom_range(0, 1) ? $urandom_range(1, 60) : $urandom_range(0, 255)));
      end else if (pick < 85) begin
        if ($urandom_range(0, 1))
          issue(REQ_READ, (ox + $urandom_range(0, 5)) % 64, (oy + $urandom_range(0, 5)) % 64, 0);
        else
          issue(REQ_READ, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
      end else if (pick < 95 && gens_here < 3) begin
        gens_here++;
        issue(REQ_GEN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
      end else begin
        issue(REQ_NONE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    req_type_i  <= REQ_WRITE;
    col_i       <= '0;
    row_i       <= '0;
    age_in_i    <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corner cells, extreme ages, a never-written cell, an unknown
    // request, and a blinker straddling the wrap at column 0 whose middle
    // cell sits at the old-age limit.
    issue(REQ_READ, 17, 42, 0);
    issue(REQ_WRITE, 63, 63, 255);
    issue(REQ_WRITE, 5, 9, 27);
    issue(REQ_WRITE, 6, 9, 10);
    issue(REQ_READ, 63, 63, 255);
    issue(REQ_READ, 5, 9, 0);
    issue(REQ_READ, 6, 9, 0);
    issue(REQ_NONE, 63, 63, 255);
    issue(REQ_WRITE, 63, 0, 1);
    issue(REQ_WRITE, 0, 0, 51);
    issue(REQ_WRITE, 1, 0, 9);
    issue(REQ_GEN, 0, 0, 0);
    issue(REQ_READ, 0, 63, 0);
    issue(REQ_READ, 0, 0, 0);
    issue(REQ_READ, 0, 1, 0);
    issue(REQ_READ, 63, 0, 0);
    issue(REQ_GEN, 63, 63, 255);
    issue(REQ_READ, 0, 0, 0);
    issue(REQ_READ, 63, 0, 0);
    issue(REQ_WRITE, 0, 0, 0);

    // Settings: loose extremes, tight extremes, random, then back to reset.
    drain();
    program_regs(1, 255, 255, 0, 0);
    random_phase(30);
    drain();
    program_regs(255, 1, 0, 8191, 8191);
    random_phase(30);
    drain();
    program_regs($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 8191), $urandom_range(0, 8191));
    random_phase(30);
    drain();
    program_regs(10, 27, 51, 50, 100);
    random_phase(30);
    drain();

    $display("tb: %0d results checked, %0d generations, five register settings",
             sb.checked, sb.gens);
    if (sb.mismatches == 0 && sb.strays == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: %0d mismatches, %0d unowed results", sb.mismatches, sb.strays);
      $display("tb: errors");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end
endmodule

>>> life_grid_aging_step.f
design/lga_pkg.sv
design/life_grid_aging_step.sv
design/lga_checker.sv
tb/tb.sv
